// ===== rtl/pes_pkg.sv =====
`default_nettype none

package pes_pkg;

	localparam int unsigned ID_W   = 16;
	localparam int unsigned PER_W  = 16;
	localparam int unsigned TIME_W = 48;

	typedef enum logic [1:0] {
		MODE_ADD   = 2'd0,
		MODE_FIRE  = 2'd1,
		MODE_CLEAR = 2'd2
	} mode_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_EMPTY = 2'd1,
		ST_FULL  = 2'd2
	} status_t;

	// one scheduled event as held by a cell
	typedef struct packed {
		logic [TIME_W-1:0] due;
		logic [ID_W-1:0]   id;
		logic [PER_W-1:0]  period;
	} ev_t;

	// operation broadcast to every cell
	typedef struct packed {
		logic ins;
		logic pop;
	} cell_op_t;

endpackage

`default_nettype wire

// ===== rtl/pes_cell.sv =====
`default_nettype none

module pes_cell import pes_pkg::*; #(
	parameter int unsigned IDX    = 0,
	parameter int unsigned SLOT_W = 6,
	parameter int unsigned CNT_W  = 7
) (
	input  wire                    clk,
	input  cell_op_t               op,
	input  wire  [CNT_W-1:0]       cnt,
	input  ev_t                    new_ev,
	input  wire  [SLOT_W-1:0]      new_slot,
	input  ev_t                    left_ev,
	input  wire  [SLOT_W-1:0]      left_slot,
	input  wire                    left_lt,
	input  ev_t                    right_ev,
	input  wire  [SLOT_W-1:0]      right_slot,
	input  wire                    right_lt,
	output ev_t                    ev,
	output logic [SLOT_W-1:0]      slot,
	output logic                   lt
);

	ev_t               ev_q;
	logic [SLOT_W-1:0] slot_q;
	logic              own_v;
	ev_t               ev_d;
	logic [SLOT_W-1:0] slot_d;

	assign own_v = ((CNT_W+1)'(IDX) < {1'b0, cnt});

	// empty cells sort as infinity; keys are unique thanks to the slot field
	assign lt = !own_v ||
		({new_ev.due, new_ev.id, new_slot} < {ev_q.due, ev_q.id, slot_q});

	always_comb begin
		ev_d   = ev_q;
		slot_d = slot_q;
		if (op.ins) begin
			if (IDX != 0 && left_lt) begin
				ev_d   = left_ev;
				slot_d = left_slot;
			end else if (lt) begin
				ev_d   = new_ev;
				slot_d = new_slot;
			end
		end else if (op.pop) begin
			// head leaves; advance the rest and drop the updated event in place
			if (!right_lt) begin
				ev_d   = right_ev;
				slot_d = right_slot;
			end else if (IDX == 0 || !lt) begin
				ev_d   = new_ev;
				slot_d = new_slot;
			end
		end
	end

	always_ff @(posedge clk) begin
		ev_q   <= ev_d;
		slot_q <= slot_d;
	end

	assign ev   = ev_q;
	assign slot = slot_q;

endmodule

`default_nettype wire

// ===== rtl/periodic_event_scheduler.sv =====
// Periodic event scheduler.
// Input channel (in_valid/in_ready) carries mode, event_id and period; output
// channel (out_valid/out_ready) carries status, fired_id and fired_time, one
// result per input item, in order.
// Events live in a sorted chain of ENTRIES cells, earliest due time at the
// head (ties by id, then by insertion order). An add shifts the later cells
// down by one; a fire reads the head, shifts the chain up and drops the
// advanced event into its new place, all in a single update of the chain.
// An accepted item is captured in the input stage; when it advances, its
// result is written to the output register. Throughput is one item per
// cycle while the receiver keeps up, set by the single update of the cell
// chain per item.
// A stalled receiver holds the result register; one more item is captured
// in the input stage, after which in_ready drops until out_ready returns.
// Reset empties the table (count to zero) and drops both stages; cell
// contents are not reset.
`default_nettype none

module periodic_event_scheduler import pes_pkg::*; #(
	parameter int unsigned ENTRIES = 64
) (
	input  wire                clk,
	input  wire                arst_n,
	input  wire                in_valid,
	output logic               in_ready,
	input  wire  [1:0]         mode,
	input  wire  [ID_W-1:0]    event_id,
	input  wire  [PER_W-1:0]   period,
	output logic               out_valid,
	input  wire                out_ready,
	output logic [1:0]         status,
	output logic [ID_W-1:0]    fired_id,
	output logic [TIME_W-1:0]  fired_time
);

	localparam int unsigned SLOT_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int unsigned CNT_W  = $clog2(ENTRIES + 1);

	logic              v_s1;
	logic [1:0]        mode_s1;
	logic [ID_W-1:0]   id_s1;
	logic [PER_W-1:0]  per_s1;

	logic [CNT_W-1:0]  cnt_q;
	logic              out_valid_q;
	logic [1:0]        status_q;
	logic [ID_W-1:0]   fired_id_q;
	logic [TIME_W-1:0] fired_time_q;

	logic              adv;
	cell_op_t          op;
	ev_t               new_ev;
	logic [SLOT_W-1:0] new_slot;
	logic [1:0]        status_d;
	logic              full;
	logic              empty;
	logic [TIME_W:0]   sum;

	ev_t               c_ev   [ENTRIES];
	logic [SLOT_W-1:0] c_slot [ENTRIES];
	logic              c_lt   [ENTRIES];

	assign adv      = v_s1 && (!out_valid_q || out_ready);
	assign in_ready = !v_s1 || adv;
	assign full     = (cnt_q >= CNT_W'(ENTRIES));
	assign empty    = (cnt_q == '0);
	assign sum      = {1'b0, c_ev[0].due} + (TIME_W+1)'(c_ev[0].period);

	always_comb begin
		op       = '0;
		status_d = ST_OK;
		new_ev   = '0;
		new_slot = cnt_q[SLOT_W-1:0];
		case (mode_s1)
			MODE_ADD: begin
				new_ev.due    = TIME_W'(per_s1);
				new_ev.id     = id_s1;
				new_ev.period = per_s1;
				if (full) begin
					status_d = ST_FULL;
				end else begin
					op.ins = adv;
				end
			end
			MODE_FIRE: begin
				// saturate the advanced due time
				new_ev        = c_ev[0];
				new_ev.due    = sum[TIME_W] ? {TIME_W{1'b1}} : sum[TIME_W-1:0];
				new_slot      = c_slot[0];
				if (empty) begin
					status_d = ST_EMPTY;
				end else begin
					op.pop = adv;
				end
			end
			default: ;
		endcase
	end

	for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
		ev_t               l_ev;
		logic [SLOT_W-1:0] l_slot;
		logic              l_lt;
		ev_t               r_ev;
		logic [SLOT_W-1:0] r_slot;
		logic              r_lt;

		if (i == 0) begin : g_first
			assign l_ev   = '0;
			assign l_slot = '0;
			assign l_lt   = 1'b0;
		end else begin : g_mid_l
			assign l_ev   = c_ev[i-1];
			assign l_slot = c_slot[i-1];
			assign l_lt   = c_lt[i-1];
		end

		if (i == ENTRIES - 1) begin : g_last
			assign r_ev   = '0;
			assign r_slot = '0;
			assign r_lt   = 1'b1;
		end else begin : g_mid_r
			assign r_ev   = c_ev[i+1];
			assign r_slot = c_slot[i+1];
			assign r_lt   = c_lt[i+1];
		end

		pes_cell #(
			.IDX    (i),
			.SLOT_W (SLOT_W),
			.CNT_W  (CNT_W)
		) u_cell (
			.clk        (clk),
			.op         (op),
			.cnt        (cnt_q),
			.new_ev     (new_ev),
			.new_slot   (new_slot),
			.left_ev    (l_ev),
			.left_slot  (l_slot),
			.left_lt    (l_lt),
			.right_ev   (r_ev),
			.right_slot (r_slot),
			.right_lt   (r_lt),
			.ev         (c_ev[i]),
			.slot       (c_slot[i]),
			.lt         (c_lt[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			out_valid_q <= 1'b0;
			cnt_q       <= '0;
		end else begin
			if (in_ready) begin
				v_s1 <= in_valid;
			end
			if (adv) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (adv && mode_s1 == MODE_CLEAR) begin
				cnt_q <= '0;
			end else if (op.ins) begin
				cnt_q <= cnt_q + CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			mode_s1 <= mode;
			id_s1   <= event_id;
			per_s1  <= period;
		end
		if (adv) begin
			status_q     <= status_d;
			fired_id_q   <= op.pop ? c_ev[0].id : '0;
			fired_time_q <= op.pop ? c_ev[0].due : '0;
		end
	end

	assign out_valid  = out_valid_q;
	assign status     = status_q;
	assign fired_id   = fired_id_q;
	assign fired_time = fired_time_q;

endmodule

`default_nettype wire

// ===== rtl/pes_checker.sv =====
`default_nettype none

module pes_checker import pes_pkg::*; (
	input wire                clk,
	input wire                arst_n,
	input wire                in_valid,
	input wire                in_ready,
	input wire                out_valid,
	input wire                out_ready,
	input wire  [1:0]         status,
	input wire  [ID_W-1:0]    fired_id,
	input wire  [TIME_W-1:0]  fired_time
);

	// hold a stalled result
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(status) &&
			$stable(fired_id) && $stable(fired_time))
		else $error("stalled result changed");

	// error results carry no event
	a_zero_fields: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status != ST_OK |-> fired_id == '0 && fired_time == '0)
		else $error("error result carries event fields");

	// input backs up only behind a stalled output
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> out_valid && !out_ready)
		else $error("input stalled without output backpressure");

	// a new result follows an input transfer that passed through the input stage
	a_cause: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_valid && in_ready, 2))
		else $error("result without an accepted item");

endmodule

bind periodic_event_scheduler pes_checker u_pes_checker (.*);

`default_nettype wire
